// File: hdl/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// Shared constants for the deadband steering low-pass block: register
// indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dsl_pkg;

    // field widths fixed by the register map and the payload
    localparam int TARGET_W = 16;
    localparam int STEER_W  = 16;
    localparam int WIDTH_W  = 12;   // image_width / deadband_pixels
    localparam int LIMIT_W  = 15;   // steer_limit, also quotient width
    localparam int WEIGHT_W = 17;   // filter_weight
    localparam int STATE_W  = 32;   // filter state, Q4.28
    localparam int FRAC_W   = 16;   // shift between steer Q4.12 and state Q4.28

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH      = 3'd0;
    localparam t_cfg_idx CFG_STEER_LIMIT      = 3'd1;
    localparam t_cfg_idx CFG_DEADBAND_PIXELS  = 3'd2;
    localparam t_cfg_idx CFG_FILTER_WEIGHT    = 3'd3;
    localparam t_cfg_idx CFG_INVERT_DIRECTION = 3'd4;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH     = 12'd320;
    localparam logic [LIMIT_W-1:0]  RST_STEER_LIMIT     = 15'd4096;
    localparam logic [WIDTH_W-1:0]  RST_DEADBAND_PIXELS = 12'd6;
    localparam logic [WEIGHT_W-1:0] RST_FILTER_WEIGHT   = 17'd16384;

    // 1.0 in Q1.16
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

endpackage

`default_nettype wire

// File: hdl/dsl_ifaces.sv
// ----------------------------------------------------------------------------
// dsl channel interfaces
// Valid/ready channels for target requests, steer results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsl_target_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dsl_pkg::TARGET_W-1:0]  target_x;

    modport source (output valid, output target_x, input ready);
    modport sink   (input valid, input target_x, output ready);
endinterface

interface dsl_steer_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dsl_pkg::STEER_W-1:0]   steer_command;

    modport source (output valid, output steer_command, input ready);
    modport sink   (input valid, input steer_command, output ready);
endinterface

interface dsl_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [dsl_pkg::CFG_IDX_W-1:0]        index;
    logic [dsl_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/deadband_steer_lowpass.sv
// ----------------------------------------------------------------------------
// deadband_steer_lowpass
// Proportional steering from a target x position with deadband, scaling,
// optional inversion and a one-pole low-pass filter on the command.
//
// Channels: i_target takes one target_x request per valid/ready handshake,
// o_steer returns exactly one steer_command (Q4.12) per request, in order.
// i_cfg writes the registers (0 image_width, 1 steer_limit, 2 deadband_pixels,
// 3 filter_weight, 4 invert_direction); it is always ready and other indexes
// are dropped. Write registers only while the block is idle.
// A nonzero error passes through the multiply, the bit-serial divide and the
// filter states; an error inside the deadband skips multiply and divide. The
// steering engine finishes one request before it takes the next.
// A 2-entry queue lets the input side take requests while the engine works.
// Reset: registers return to defaults and the filter state clears to zero.
// A stalled o_steer holds the result in its output register; the engine
// then waits, the queue fills and i_target.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module deadband_steer_lowpass #(
    parameter int COORD_WIDTH = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dsl_target_if.sink  i_target,
    dsl_steer_if.source o_steer,
    dsl_cfg_if.sink     i_cfg
);

    // only the low COORD_WIDTH bits of the 12-bit width/deadband count
    localparam int WW = (COORD_WIDTH < dsl_pkg::WIDTH_W) ? COORD_WIDTH : dsl_pkg::WIDTH_W;

    logic [dsl_pkg::WIDTH_W-1:0]  r_image_width;
    logic [dsl_pkg::LIMIT_W-1:0]  r_steer_limit;
    logic [dsl_pkg::WIDTH_W-1:0]  r_deadband;
    logic [dsl_pkg::WEIGHT_W-1:0] r_weight;
    logic                         r_invert;

    logic                         q_push;
    logic                         q_pop;
    logic                         q_full;
    logic                         q_empty;
    logic [WW+1:0]                q_wdata;
    logic [WW+1:0]                q_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= dsl_pkg::RST_IMAGE_WIDTH;
            r_steer_limit <= dsl_pkg::RST_STEER_LIMIT;
            r_deadband    <= dsl_pkg::RST_DEADBAND_PIXELS;
            r_weight      <= dsl_pkg::RST_FILTER_WEIGHT;
            r_invert      <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dsl_pkg::CFG_IMAGE_WIDTH:      r_image_width <= i_cfg.data[dsl_pkg::WIDTH_W-1:0];
                dsl_pkg::CFG_STEER_LIMIT:      r_steer_limit <= i_cfg.data[dsl_pkg::LIMIT_W-1:0];
                dsl_pkg::CFG_DEADBAND_PIXELS:  r_deadband    <= i_cfg.data[dsl_pkg::WIDTH_W-1:0];
                dsl_pkg::CFG_FILTER_WEIGHT:    r_weight      <= i_cfg.data;
                dsl_pkg::CFG_INVERT_DIRECTION: r_invert      <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    dsl_front #(
        .WW (WW)
    ) u_front (
        .i_tgt      (i_target),
        .i_width    (r_image_width[WW-1:0]),
        .i_deadband (r_deadband[WW-1:0]),
        .i_invert   (r_invert),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    dsl_fifo #(
        .WIDTH (WW + 2),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dsl_back #(
        .WW (WW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_width   (r_image_width[WW-1:0]),
        .i_limit   (r_steer_limit),
        .i_weight  (r_weight),
        .o_steer   (o_steer)
    );

endmodule

`default_nettype wire

// File: hdl/dsl_front.sv
// ----------------------------------------------------------------------------
// dsl_front
// Accepts target requests, clamps x, forms the half-pixel error, applies the
// deadband and pushes {zero, negative, magnitude} into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_front #(
    parameter int WW = 12
) (
    dsl_target_if.sink          i_tgt,
    input  wire [WW-1:0]        i_width,
    input  wire [WW-1:0]        i_deadband,
    input  wire                 i_invert,
    input  wire                 i_q_full,
    output logic                o_q_push,
    output logic [WW+1:0]       o_q_data
);

    logic signed [dsl_pkg::TARGET_W-1:0] w_s;
    logic [WW-1:0]                       x_c;
    logic signed [WW+1:0]                err;
    logic [WW+1:0]                       err_abs;
    logic [WW-1:0]                       mag;
    logic [WW:0]                         db2;
    logic                                is_zero;
    logic                                is_neg;

    assign i_tgt.ready = !i_q_full;
    assign o_q_push    = i_tgt.valid && !i_q_full;

    always_comb begin
        w_s = dsl_pkg::TARGET_W'(i_width);
        if (i_tgt.target_x[dsl_pkg::TARGET_W-1]) begin
            x_c = '0;
        end else if (i_tgt.target_x > w_s) begin
            x_c = i_width;
        end else begin
            x_c = i_tgt.target_x[WW-1:0];
        end

        // error in half pixels: width - 2x, lies in [-width, width]
        err     = $signed({2'b00, i_width}) - $signed({1'b0, x_c, 1'b0});
        err_abs = err[WW+1] ? (WW+2)'(-err) : err;
        db2     = {i_deadband, 1'b0};
        mag     = ({1'b0, err_abs[WW-1:0]} < db2) ? '0 : err_abs[WW-1:0];
        is_zero = (mag == '0);
        is_neg  = err[WW+1] ^ i_invert;
        o_q_data = {is_zero, is_neg, mag};
    end

endmodule

`default_nettype wire

// File: hdl/dsl_fifo.sv
// ----------------------------------------------------------------------------
// dsl_fifo
// Small register-based queue between the classifier and the steering engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_fifo #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire [WIDTH-1:0]     i_data,
    input  wire                 i_pop,
    output logic [WIDTH-1:0]    o_data,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dsl_back.sv
// ----------------------------------------------------------------------------
// dsl_back
// Steering engine: scales the error by steer_limit, divides by the width
// one quotient bit per cycle, applies the sign and updates the low-pass state.
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_back #(
    parameter int WW = 12
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire [WW+1:0]                    i_q_data,
    input  wire                             i_q_empty,
    output logic                            o_q_pop,
    input  wire [WW-1:0]                    i_width,
    input  wire [dsl_pkg::LIMIT_W-1:0]      i_limit,
    input  wire [dsl_pkg::WEIGHT_W-1:0]     i_weight,
    dsl_steer_if.source                     o_steer
);

    localparam int QW  = dsl_pkg::LIMIT_W;
    localparam int CNW = $clog2(QW);
    localparam int SW  = dsl_pkg::STATE_W;
    localparam int PRW = SW + 1 + dsl_pkg::WEIGHT_W + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FILT = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state                          r_st, n_st;
    logic [WW-1:0]                   r_mag;
    logic                            r_neg;
    logic                            r_zero;
    logic [WW-1:0]                   r_rem;
    logic [QW-1:0]                   r_low;   // low dividend bits, then quotient
    logic [CNW-1:0]                  r_cnt;
    logic signed [PRW-1:0]           r_wprod;
    logic signed [SW-1:0]            r_state;
    logic                            r_out_valid;
    logic signed [dsl_pkg::STEER_W-1:0] r_out;

    logic [WW+QW-1:0]                scaled;
    logic [WW:0]                     trial;
    logic                            ge;
    logic signed [dsl_pkg::STEER_W-1:0] steer;
    logic signed [SW:0]              diff;
    logic [dsl_pkg::WEIGHT_W-1:0]    weight;
    logic signed [PRW-1:0]           prod;
    logic signed [SW-1:0]            next_state;
    logic                            out_free;

    assign o_steer.valid         = r_out_valid;
    assign o_steer.steer_command = r_out;
    assign out_free              = !r_out_valid || o_steer.ready;
    assign o_q_pop               = (r_st == S_IDLE) && !i_q_empty;

    always_comb begin
        scaled = (WW+QW)'(r_mag) * (WW+QW)'(i_limit);
        trial  = {r_rem, r_low[QW-1]};
        ge     = (trial >= {1'b0, i_width});

        if (r_zero) begin
            steer = '0;
        end else if (r_neg) begin
            steer = -$signed({1'b0, r_low});
        end else begin
            steer = $signed({1'b0, r_low});
        end

        weight = (i_weight > dsl_pkg::WEIGHT_ONE) ? dsl_pkg::WEIGHT_ONE : i_weight;
        diff   = $signed({steer, {dsl_pkg::FRAC_W{1'b0}}})
               - $signed({r_state[SW-1], r_state});
        prod   = $signed({1'b0, weight}) * diff;
        // arithmetic shift gives the floor; result stays between state and target
        next_state = r_state + SW'(r_wprod >>> dsl_pkg::FRAC_W);
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_st = i_q_data[WW+1] ? S_FILT : S_MUL;
                end
            end
            S_MUL:  n_st = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_st = S_FILT;
                end
            end
            S_FILT: n_st = S_UPD;
            S_UPD: begin
                if (out_free) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_UPD && out_free) begin
                r_state     <= next_state;
                r_out_valid <= 1'b1;
            end else if (o_steer.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_zero <= i_q_data[WW+1];
                r_neg  <= i_q_data[WW];
                r_mag  <= i_q_data[WW-1:0];
            end
            S_MUL: begin
                // quotient fits QW bits, so the top bits start below the width
                r_rem <= scaled[WW+QW-1:QW];
                r_low <= scaled[QW-1:0];
                r_cnt <= CNW'(QW - 1);
            end
            S_DIV: begin
                r_rem <= ge ? WW'(trial - {1'b0, i_width}) : trial[WW-1:0];
                r_low <= {r_low[QW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_FILT: begin
                r_wprod <= prod;
            end
            S_UPD: begin
                if (out_free) begin
                    r_out <= next_state[SW-1 -: dsl_pkg::STEER_W];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sim/steer_response_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steer_response_checker
// Watches the target, steer and register channels of deadband_steer_lowpass,
// predicts each filtered steer command and compares it with the returned one.
// ----------------------------------------------------------------------------

module steer_response_checker #(
    parameter int COORD_WIDTH = 12
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    dsl_target_if i_target,
    dsl_steer_if  i_steer,
    dsl_cfg_if    i_cfg,
    output int    o_mismatches,
    output int    o_in_flight
);

    localparam longint COORD_MASK = (longint'(1) << COORD_WIDTH) - 1;

    logic [dsl_pkg::WIDTH_W-1:0]  image_width;
    logic [dsl_pkg::LIMIT_W-1:0]  steer_limit;
    logic [dsl_pkg::WIDTH_W-1:0]  deadband_pixels;
    logic [dsl_pkg::WEIGHT_W-1:0] filter_weight;
    logic                         invert_direction;
    logic signed [dsl_pkg::STATE_W-1:0] filter_state;

    logic signed [dsl_pkg::STEER_W-1:0] steer_expected[$];
    logic signed [dsl_pkg::STEER_W-1:0] steer_want;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_mismatches = o_mismatches + 1;
    endtask

    // one filter step for a new target position, returns the next Q4.28 state
    function automatic logic signed [dsl_pkg::STATE_W-1:0] filter_update(
        input logic signed [dsl_pkg::STATE_W-1:0]  cur,
        input logic signed [dsl_pkg::TARGET_W-1:0] x_in
    );
        longint w, db2, x, err, mag, cmd, wt, delta;
        w   = longint'(image_width) & COORD_MASK;
        db2 = 2 * (longint'(deadband_pixels) & COORD_MASK);
        x   = longint'(x_in);
        if (x < 0)
            x = 0;
        if (x > w)
            x = w;
        err = w - 2 * x;
        mag = (err < 0) ? -err : err;
        if (mag < db2)
            mag = 0;
        if (w == 0 || mag == 0) begin
            cmd = 0;
        end else begin
            cmd = (mag * longint'(steer_limit)) / w;
            if (err < 0)
                cmd = -cmd;
        end
        if (invert_direction)
            cmd = -cmd;
        wt = longint'(filter_weight);
        if (wt > longint'(dsl_pkg::WEIGHT_ONE))
            wt = longint'(dsl_pkg::WEIGHT_ONE);
        // arithmetic shift of a signed value is the floor division
        delta = wt * ((cmd <<< dsl_pkg::FRAC_W) - longint'(cur));
        return dsl_pkg::STATE_W'(longint'(cur) + (delta >>> dsl_pkg::FRAC_W));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            image_width      <= dsl_pkg::RST_IMAGE_WIDTH;
            steer_limit      <= dsl_pkg::RST_STEER_LIMIT;
            deadband_pixels  <= dsl_pkg::RST_DEADBAND_PIXELS;
            filter_weight    <= dsl_pkg::RST_FILTER_WEIGHT;
            invert_direction <= 1'b0;
            filter_state     = '0;
            steer_expected.delete();
            o_in_flight      <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    dsl_pkg::CFG_IMAGE_WIDTH:
                        image_width      <= i_cfg.data[dsl_pkg::WIDTH_W-1:0];
                    dsl_pkg::CFG_STEER_LIMIT:
                        steer_limit      <= i_cfg.data[dsl_pkg::LIMIT_W-1:0];
                    dsl_pkg::CFG_DEADBAND_PIXELS:
                        deadband_pixels  <= i_cfg.data[dsl_pkg::WIDTH_W-1:0];
                    dsl_pkg::CFG_FILTER_WEIGHT:
                        filter_weight    <= i_cfg.data[dsl_pkg::WEIGHT_W-1:0];
                    dsl_pkg::CFG_INVERT_DIRECTION:
                        invert_direction <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_target.valid && i_target.ready) begin
                filter_state = filter_update(filter_state, i_target.target_x);
                steer_expected.push_back(filter_state[dsl_pkg::STATE_W-1 -: dsl_pkg::STEER_W]);
            end
            if (i_steer.valid && i_steer.ready) begin
                if (steer_expected.size() == 0) begin
                    report_mismatch($sformatf("steer %0d with no request pending",
                                              i_steer.steer_command));
                end else begin
                    steer_want = steer_expected.pop_front();
                    if (i_steer.steer_command !== steer_want)
                        report_mismatch($sformatf("steer_command got %0d want %0d",
                                                  i_steer.steer_command, steer_want));
                end
            end
            o_in_flight <= steer_expected.size();
        end
    end

endmodule

// File: sim/deadband_steer_lowpass_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_steer_lowpass_test
// Drives target requests and register writes into deadband_steer_lowpass with
// random idling on both sides; a checker beside the block predicts and
// compares every steer result. Directed corners first, then random settings.
// ----------------------------------------------------------------------------

module deadband_steer_lowpass_test;

    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   quiet_cycles;
    int   mismatches;
    int   in_flight;

    dsl_target_if target_ch();
    dsl_steer_if  steer_ch();
    dsl_cfg_if    cfg_ch();

    deadband_steer_lowpass i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_target (target_ch),
        .o_steer  (steer_ch),
        .i_cfg    (cfg_ch)
    );

    steer_response_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_target     (target_ch),
        .i_steer      (steer_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_in_flight  (in_flight)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        steer_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // no handshake of any kind for too long means the block hung
    always @(posedge i_clk) begin
        if ((target_ch.valid && target_ch.ready) || (steer_ch.valid && steer_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input dsl_pkg::t_cfg_idx idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= dsl_pkg::CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic load_settings(input int width, input int limit, input int deadband,
                                 input int weight, input int invert);
        write_reg(dsl_pkg::CFG_IMAGE_WIDTH, width);
        write_reg(dsl_pkg::CFG_STEER_LIMIT, limit);
        write_reg(dsl_pkg::CFG_DEADBAND_PIXELS, deadband);
        write_reg(dsl_pkg::CFG_FILTER_WEIGHT, weight);
        write_reg(dsl_pkg::CFG_INVERT_DIRECTION, invert);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_target(input int x);
        while ($urandom_range(99) < tx_idle_pct) begin
            target_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        target_ch.valid    <= 1'b1;
        target_ch.target_x <= dsl_pkg::TARGET_W'(x);
        do @(posedge i_clk); while (!target_ch.ready);
    endtask

    // hold requests until every result is back
    task automatic drain_results();
        target_ch.valid <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0);
    endtask

    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin tx_idle_pct = 28; rx_idle_pct = 79; end
            1: begin tx_idle_pct = 79; rx_idle_pct = 28; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
    endtask

    function automatic int pick_target(input int width, input int deadband);
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return int'($urandom_range(width + 2)) - 1;
        else if (roll < 80)   // around the deadband edges
            return width / 2 - deadband - 2 + int'($urandom_range(2 * deadband + 4));
        else
            return int'($signed(16'($urandom_range(16'hFFFF))));
    endfunction

    initial begin
        int width, limit, deadband, weight;

        set_idle_mode(0);
        i_rst_n            <= 1'b0;
        target_ch.valid    <= 1'b0;
        target_ch.target_x <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, center, both sides of the deadband edge
        send_target(-32768);
        send_target(32767);
        send_target(0);
        send_target(320);
        send_target(160);
        send_target(154);
        send_target(155);
        send_target(1);
        quiesce();

        // unused indexes must be dropped
        for (int k = dsl_pkg::CFG_INVERT_DIRECTION + 1; k < 2 ** dsl_pkg::CFG_IDX_W; k++)
            write_reg(dsl_pkg::t_cfg_idx'(k), $urandom_range(2 ** dsl_pkg::CFG_DATA_W - 1));
        cfg_ch.valid <= 1'b0;

        // widest image, largest limit, weight past one saturates, inverted
        load_settings(4095, 32767, 0, 131071, 1);
        send_target(0);
        send_target(4095);
        send_target(2047);
        send_target(2048);
        send_target(-1);
        quiesce();

        // zero weight freezes the state
        load_settings(7, 32767, 1, 0, 0);
        send_target(0);
        send_target(7);
        send_target(3);
        quiesce();

        // zero width: no division, command zero
        load_settings(0, 32767, 4095, 65536, 0);
        send_target(100);
        send_target(-5);
        quiesce();

        load_settings(2, 1, 0, 1, 0);
        send_target(0);
        send_target(2);
        send_target(1);
        quiesce();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idle_mode(phase * 3 / RANDOM_PHASES);
            case ($urandom_range(5))
                0: width = 1;
                1: width = 4095;
                2: width = $urandom_range(2, 64);
                default: width = $urandom_range(1, 4095);
            endcase
            case ($urandom_range(7))
                0: limit = 0;
                1: limit = 32767;
                default: limit = $urandom_range(32767);
            endcase
            case ($urandom_range(3))
                0: deadband = 0;
                1: deadband = $urandom_range(4095);
                default: deadband = $urandom_range(width / 8);
            endcase
            case ($urandom_range(4))
                0: weight = 65536;
                1: weight = $urandom_range(65537, 131071);
                2: weight = $urandom_range(1, 512);
                default: weight = $urandom_range(65535);
            endcase
            load_settings(width, limit, deadband, weight, $urandom_range(1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                send_target(pick_target(width, deadband));
            end
            quiesce();
        end

        if (mismatches == 0 && in_flight == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
